// File: rtl/mbfc_pkg.sv
// Package for the magic byte format classifier.
// Format codes, signature indexes and the signature byte table. No dependencies.
package mbfc_pkg;

  localparam int SigCount  = 49;
  localparam int CountMax  = 263;
  localparam int CntW      = 9;
  localparam int FmtW      = 7;
  localparam int ConfW     = 7;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 16;

  // Format codes
  localparam logic [6:0] F_NONE = 7'd0;
  localparam logic [6:0] F_JPEG = 7'd1;
  localparam logic [6:0] F_PNG  = 7'd2;
  localparam logic [6:0] F_GIF  = 7'd3;
  localparam logic [6:0] F_BMP  = 7'd4;
  localparam logic [6:0] F_TIFF = 7'd5;
  localparam logic [6:0] F_WEBP = 7'd6;
  localparam logic [6:0] F_JXL  = 7'd7;
  localparam logic [6:0] F_AVIF = 7'd8;
  localparam logic [6:0] F_HEIC = 7'd9;
  localparam logic [6:0] F_CR2  = 7'd11;
  localparam logic [6:0] F_CR3  = 7'd12;
  localparam logic [6:0] F_RAF  = 7'd17;
  localparam logic [6:0] F_DNG  = 7'd19;
  localparam logic [6:0] F_MRW  = 7'd21;
  localparam logic [6:0] F_ZIP  = 7'd27;
  localparam logic [6:0] F_CBZ  = 7'd28;
  localparam logic [6:0] F_RAR  = 7'd29;
  localparam logic [6:0] F_CBR  = 7'd30;
  localparam logic [6:0] F_7Z   = 7'd31;
  localparam logic [6:0] F_CB7  = 7'd32;
  localparam logic [6:0] F_TAR  = 7'd33;
  localparam logic [6:0] F_GZ   = 7'd34;
  localparam logic [6:0] F_BZ2  = 7'd35;
  localparam logic [6:0] F_XZ   = 7'd36;
  localparam logic [6:0] F_ZSTD = 7'd37;
  localparam logic [6:0] F_PDF  = 7'd38;
  localparam logic [6:0] F_EPUB = 7'd39;
  localparam logic [6:0] F_DOCX = 7'd40;
  localparam logic [6:0] F_XLSX = 7'd41;
  localparam logic [6:0] F_PPTX = 7'd42;
  localparam logic [6:0] F_MP4  = 7'd43;
  localparam logic [6:0] F_MKV  = 7'd44;
  localparam logic [6:0] F_FLAC = 7'd48;
  localparam logic [6:0] F_MP3  = 7'd49;
  localparam logic [6:0] F_OGG  = 7'd50;
  localparam logic [6:0] F_WAV  = 7'd51;
  localparam logic [6:0] F_EXR  = 7'd52;
  localparam logic [6:0] F_HDR  = 7'd53;
  localparam logic [6:0] F_PSD  = 7'd54;
  localparam logic [6:0] F_DDS  = 7'd55;
  localparam logic [6:0] F_FONT = 7'd59;
  localparam logic [6:0] F_GLB  = 7'd60;
  localparam logic [6:0] F_FITS = 7'd65;
  localparam logic [6:0] F_ICO  = 7'd67;
  localparam logic [6:0] F_LAST = 7'd67;

  // Confidence values
  localparam logic [6:0] C_0   = 7'd0;
  localparam logic [6:0] C_40  = 7'd40;
  localparam logic [6:0] C_50  = 7'd50;
  localparam logic [6:0] C_80  = 7'd80;
  localparam logic [6:0] C_90  = 7'd90;
  localparam logic [6:0] C_95  = 7'd95;
  localparam logic [6:0] C_100 = 7'd100;

  // Signature indexes
  localparam int S_JPEG = 0, S_PNG = 1, S_GIF89 = 2, S_GIF87 = 3, S_RIFF = 4;
  localparam int S_BMP = 5, S_ICO = 6, S_TIFFLE = 7, S_TIFFBE = 8, S_FITS = 9;
  localparam int S_EXR = 10, S_HDR = 11, S_DDS = 12, S_PSD = 13, S_JXL = 14;
  localparam int S_JXLBOX = 15, S_RAF = 16, S_MRW = 17, S_ZIP = 18, S_ZIPE = 19;
  localparam int S_RAR4 = 20, S_RAR5 = 21, S_7Z = 22, S_GZ = 23, S_BZ2 = 24;
  localparam int S_XZ = 25, S_ZSTD = 26, S_PDF = 27, S_MKV = 28, S_FLAC = 29;
  localparam int S_ID3 = 30, S_SYNC = 31, S_OGG = 32, S_TTF = 33, S_OTF = 34;
  localparam int S_WOFF = 35, S_WOFF2 = 36, S_GLB = 37, S_WEBP8 = 38;
  localparam int S_WAVE8 = 39, S_CR8 = 40, S_FTYP4 = 41, S_AVIF8 = 42;
  localparam int S_AVIS8 = 43, S_HEIC8 = 44, S_MIF18 = 45, S_CRXL8 = 46;
  localparam int S_CRXU8 = 47, S_TAR = 48;

  typedef logic [SigCount-1:0] flags_t;

  typedef struct packed {
    logic [8:0]  off;
    logic [3:0]  len;
    logic [79:0] b;   // byte 0 in the top bits
  } sig_t;

  typedef sig_t sig_tab_t [SigCount];

  localparam sig_tab_t SIGS = '{
    '{9'd0, 4'd3, 80'hFFD8FF00000000000000},
    '{9'd0, 4'd8, 80'h89504E470D0A1A0A0000},
    '{9'd0, 4'd6, 80'h47494638396100000000},
    '{9'd0, 4'd6, 80'h47494638376100000000},
    '{9'd0, 4'd4, 80'h52494646000000000000},
    '{9'd0, 4'd2, 80'h424D0000000000000000},
    '{9'd0, 4'd4, 80'h00000100000000000000},
    '{9'd0, 4'd4, 80'h49492A00000000000000},
    '{9'd0, 4'd4, 80'h4D4D002A000000000000},
    '{9'd0, 4'd8, 80'h53494D504C4520200000},
    '{9'd0, 4'd4, 80'h762F3101000000000000},
    '{9'd0, 4'd10, 80'h233F52414449414E4345},
    '{9'd0, 4'd4, 80'h44445320000000000000},
    '{9'd0, 4'd4, 80'h38425053000000000000},
    '{9'd0, 4'd2, 80'hFF0A0000000000000000},
    '{9'd0, 4'd8, 80'h0000000C4A584C200000},
    '{9'd0, 4'd8, 80'h46554A4946494C4D0000},
    '{9'd0, 4'd4, 80'h004D524D000000000000},
    '{9'd0, 4'd4, 80'h504B0304000000000000},
    '{9'd0, 4'd4, 80'h504B0506000000000000},
    '{9'd0, 4'd7, 80'h526172211A0700000000},
    '{9'd0, 4'd8, 80'h526172211A0701000000},
    '{9'd0, 4'd6, 80'h377ABCAF271C00000000},
    '{9'd0, 4'd2, 80'h1F8B0000000000000000},
    '{9'd0, 4'd3, 80'h425A6800000000000000},
    '{9'd0, 4'd6, 80'hFD377A585A0000000000},
    '{9'd0, 4'd4, 80'h28B52FFD000000000000},
    '{9'd0, 4'd4, 80'h25504446000000000000},
    '{9'd0, 4'd4, 80'h1A45DFA3000000000000},
    '{9'd0, 4'd4, 80'h664C6143000000000000},
    '{9'd0, 4'd3, 80'h49443300000000000000},
    '{9'd0, 4'd2, 80'hFFFB0000000000000000},
    '{9'd0, 4'd4, 80'h4F676753000000000000},
    '{9'd0, 4'd5, 80'h00010000000000000000},
    '{9'd0, 4'd4, 80'h4F54544F000000000000},
    '{9'd0, 4'd4, 80'h774F4646000000000000},
    '{9'd0, 4'd4, 80'h774F4632000000000000},
    '{9'd0, 4'd4, 80'h676C5446000000000000},
    '{9'd8, 4'd4, 80'h57454250000000000000},
    '{9'd8, 4'd4, 80'h57415645000000000000},
    '{9'd8, 4'd2, 80'h43520000000000000000},
    '{9'd4, 4'd4, 80'h66747970000000000000},
    '{9'd8, 4'd4, 80'h61766966000000000000},
    '{9'd8, 4'd4, 80'h61766973000000000000},
    '{9'd8, 4'd4, 80'h68656963000000000000},
    '{9'd8, 4'd4, 80'h6D696631000000000000},
    '{9'd8, 4'd4, 80'h63727820000000000000},
    '{9'd8, 4'd4, 80'h43525820000000000000},
    '{9'd257, 4'd5, 80'h75737461720000000000}
  };

  // Word from the tracker to the decision stage
  typedef struct packed {
    logic [CntW-1:0] cnt;
    flags_t          flags;
    logic [FmtW-1:0] ext;
    logic            have;
  } trk_out_t;

endpackage

// File: rtl/mbfc_tracker.sv
// Byte tracker: saturating byte count and per-signature match flags.
// Depends on mbfc_pkg.
module mbfc_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            data,
  input  logic                  last,
  input  logic [6:0]            ext_format,
  input  logic                  ext_present,
  output mbfc_pkg::trk_out_t    done
);
  import mbfc_pkg::*;

  logic [CntW-1:0] cnt_r, cnt_nxt;
  flags_t          flags_r, flags_nxt;

  // Clear each flag whose window covers this byte and disagrees
  always_comb begin
    logic [CntW:0] rel;
    logic [3:0]    idx;
    logic [7:0]    exp_b;
    flags_nxt = flags_r;
    for (int s = 0; s < SigCount; s++) begin
      rel   = {1'b0, cnt_r} - {1'b0, SIGS[s].off};
      idx   = rel[3:0];
      exp_b = SIGS[s].b[79 - 8*idx -: 8];
      if (cnt_r >= SIGS[s].off && rel < {6'd0, SIGS[s].len} && data != exp_b)
        flags_nxt[s] = 1'b0;
    end
    cnt_nxt = (cnt_r == CntW'(CountMax)) ? cnt_r : cnt_r + 1'b1;
  end

  // Hand the finished state to the decision stage
  always_comb begin
    done.cnt   = cnt_nxt;
    done.flags = flags_nxt;
    done.ext   = ext_present ? ext_format : F_NONE;
    done.have  = ext_present;
  end

  // Advance, return to reset after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      flags_r <= '1;
    end else if (step) begin
      if (last) begin
        cnt_r   <= '0;
        flags_r <= '1;
      end else begin
        cnt_r   <= cnt_nxt;
        flags_r <= flags_nxt;
      end
    end
  end

  property p_cnt_sat;
    @(posedge clk) disable iff (!rst_n) cnt_r <= CntW'(CountMax);
  endproperty
  a_cnt_sat: assert property (p_cnt_sat) else $error("byte count past saturation");

  property p_flags_clear;
    @(posedge clk) disable iff (!rst_n) (step && last) |=> (cnt_r == '0 && flags_r == '1);
  endproperty
  a_flags_clear: assert property (p_flags_clear) else $error("state not cleared after file");

  property p_flags_drop;
    @(posedge clk) disable iff (!rst_n) (step && !last) |=> ((flags_r & ~$past(flags_r)) == '0);
  endproperty
  a_flags_drop: assert property (p_flags_drop) else $error("match flag came back mid file");
endmodule

// File: rtl/mbfc_decide.sv
// Decision logic: priority chain over the match flags and extension fallback.
// Depends on mbfc_pkg.
module mbfc_decide (
  input  mbfc_pkg::trk_out_t   st,
  output logic [6:0]           fmt,
  output logic [6:0]           conf
);
  import mbfc_pkg::*;

  flags_t h;

  // A signature hits when its flag holds and its window was fully seen
  always_comb begin
    for (int s = 0; s < SigCount; s++)
      h[s] = st.flags[s] && ({1'b0, st.cnt} >= ({1'b0, SIGS[s].off} + 10'(SIGS[s].len)));
  end

  always_comb begin
    logic [6:0] e, eb;
    e  = st.ext;
    eb = (e <= F_LAST) ? e : F_NONE;
    fmt  = F_NONE;
    conf = C_100;
    if (st.cnt < 9'd2) begin
      fmt  = st.have ? eb : F_NONE;
      conf = st.have ? C_40 : C_0;
    end
    else if (h[S_JPEG]) fmt = F_JPEG;
    else if (h[S_PNG]) fmt = F_PNG;
    else if (h[S_GIF89] || h[S_GIF87]) fmt = F_GIF;
    else if (h[S_RIFF] && h[S_WEBP8]) fmt = F_WEBP;
    else if (h[S_RIFF] && h[S_WAVE8]) fmt = F_WAV;
    else if (h[S_BMP]) fmt = F_BMP;
    else if (h[S_ICO]) fmt = F_ICO;
    else if (h[S_TIFFLE]) fmt = h[S_CR8] ? F_CR2 : ((e == F_DNG) ? F_DNG : F_TIFF);
    else if (h[S_TIFFBE]) fmt = F_TIFF;
    else if (h[S_FITS]) fmt = F_FITS;
    else if (h[S_EXR]) fmt = F_EXR;
    else if (h[S_HDR]) fmt = F_HDR;
    else if (h[S_DDS]) fmt = F_DDS;
    else if (h[S_PSD]) fmt = F_PSD;
    else if (h[S_JXL]) begin fmt = F_JXL; conf = C_95; end
    else if (h[S_JXLBOX]) fmt = F_JXL;
    else if (st.cnt >= 9'd12 && h[S_FTYP4]) begin
      if (h[S_AVIF8] || h[S_AVIS8]) fmt = F_AVIF;
      else if (h[S_HEIC8] || h[S_MIF18]) fmt = F_HEIC;
      else if (h[S_CRXL8] || h[S_CRXU8]) fmt = F_CR3;
      else fmt = F_MP4;
    end
    else if (h[S_RAF]) fmt = F_RAF;
    else if (h[S_MRW]) fmt = F_MRW;
    else if (h[S_ZIP] || h[S_ZIPE]) begin
      if (e == F_EPUB || e == F_CBZ || e == F_DOCX || e == F_XLSX || e == F_PPTX) fmt = e;
      else fmt = F_ZIP;
      conf = C_90;
    end
    else if (h[S_RAR4] || h[S_RAR5]) fmt = (e == F_CBR) ? F_CBR : F_RAR;
    else if (h[S_7Z]) fmt = (e == F_CB7) ? F_CB7 : F_7Z;
    else if (h[S_GZ]) fmt = F_GZ;
    else if (h[S_BZ2]) fmt = F_BZ2;
    else if (h[S_XZ]) fmt = F_XZ;
    else if (h[S_ZSTD]) fmt = F_ZSTD;
    else if (st.cnt >= 9'(CountMax) && h[S_TAR]) fmt = F_TAR;
    else if (h[S_PDF]) fmt = F_PDF;
    else if (h[S_MKV]) begin fmt = F_MKV; conf = C_90; end
    else if (h[S_FLAC]) fmt = F_FLAC;
    else if (h[S_ID3]) fmt = F_MP3;
    else if (h[S_SYNC]) begin fmt = F_MP3; conf = C_80; end
    else if (h[S_OGG]) fmt = F_OGG;
    else if (h[S_TTF]) begin fmt = F_FONT; conf = C_90; end
    else if (h[S_OTF] || h[S_WOFF] || h[S_WOFF2]) fmt = F_FONT;
    else if (h[S_GLB]) fmt = F_GLB;
    else begin
      // No match: extension fallback
      fmt  = st.have ? eb : F_NONE;
      conf = st.have ? C_50 : C_0;
    end
  end
endmodule

// File: rtl/magic_byte_format_classifier.sv
// Top level of the magic byte format classifier: tracker, decision, output register.
// Depends on mbfc_pkg, mbfc_tracker, mbfc_decide.
//
//  channel | dir | fields
//  in_     | in  | tdata {ext_present, ext_format, data}, tlast = last
//  out_    | out | tdata {confidence_pct, format_code}
//
// One byte is taken every cycle while the input is ready; the result of a file appears in the cycle after
// its last byte is accepted, in the output register. Reset (rst_n low, synchronous)
// clears the count, flags and output valid. Input is ready whenever the output
// register is empty or being drained, so a stalled result holds off all input words.
module magic_byte_format_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mbfc_pkg::IN_DATA_W-1:0]   in_tdata,  // data[7:0], ext_format[14:8], ext_present[15]
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mbfc_pkg::OUT_DATA_W-1:0]  out_tdata  // format_code[6:0], confidence_pct[13:7]
);
  import mbfc_pkg::*;

  logic       step;
  trk_out_t   st;
  logic [6:0] fmt, conf;
  logic       vld_r;
  logic [6:0] fmt_r, conf_r;

  assign in_tready = !vld_r || out_tready;
  assign step      = in_tvalid && in_tready;

  mbfc_tracker u_trk (
    .clk(clk), .rst_n(rst_n), .step(step),
    .data(in_tdata[7:0]), .last(in_tlast),
    .ext_format(in_tdata[14:8]), .ext_present(in_tdata[15]),
    .done(st)
  );

  mbfc_decide u_dec (.st(st), .fmt(fmt), .conf(conf));

  // Hold a result until taken, load a new one on a last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (step && in_tlast) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_tlast) begin
      fmt_r  <= fmt;
      conf_r <= conf;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {2'b00, conf_r, fmt_r};

  property p_stall_hold;
    @(posedge clk) disable iff (!rst_n) (out_tvalid && !out_tready) |=> $stable(out_tdata);
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("result changed while stalled");

  property p_conf_range;
    @(posedge clk) disable iff (!rst_n) out_tvalid |-> (conf_r <= C_100);
  endproperty
  a_conf_range: assert property (p_conf_range) else $error("confidence out of range");

  property p_load;
    @(posedge clk) disable iff (!rst_n) (step && in_tlast) |=> out_tvalid;
  endproperty
  a_load: assert property (p_load) else $error("result lost");
endmodule
